### rtl/bcrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrm_pkg
// Shared constants and types for the binned conditional rate mean unit.
// ----------------------------------------------------------------------------
package bcrm_pkg;

   // default for the window size limit, 2^MAX_BIN_BITS sites per window
   localparam int MAX_BIN_BITS_DEF = 20;

   // windows that may wait between the front and the shared divider
   localparam int QUEUE_DEPTH = 4;

   // fixed field widths
   localparam int INTERVAL_W = 8;
   localparam int RATE_W     = 32;
   localparam int CHAR_W     = 8;
   localparam int BIN_W      = 21;
   localparam int WIN_W      = 24;
   localparam int RATIO_W    = 32;
   localparam int Q16_SHIFT  = 16;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_MISSING = 8'h32;
   localparam logic [CHAR_W-1:0] CHAR_SNP     = 8'h31;

   // register defaults
   localparam logic [INTERVAL_W-1:0] DEF_LOW  = 8'd0;
   localparam logic [INTERVAL_W-1:0] DEF_HIGH = 8'd40;
   localparam logic [BIN_W-1:0]      DEF_BIN  = 21'd10000;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SIZE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_ENABLE    = 2'd3;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MEAN,
      BK_MISS,
      BK_DIV,
      BK_OUT
   } back_state_type;

endpackage
`default_nettype wire

### rtl/bcrm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrm_front
// Holds the configuration registers, classifies each site and accumulates the
// window sums; pushes one job into the queue when a window closes.
// ----------------------------------------------------------------------------
module bcrm_front #(
   parameter int MAX_BIN_BITS = bcrm_pkg::MAX_BIN_BITS_DEF,
   parameter int CNT_W        = MAX_BIN_BITS + 1,
   parameter int SUM_W        = bcrm_pkg::RATE_W + MAX_BIN_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [bcrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bcrm_pkg::BIN_W-1:0]      csr_data,
   // sites
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [bcrm_pkg::INTERVAL_W-1:0] req_interval_index,
   input  wire logic [bcrm_pkg::RATE_W-1:0]     req_rate_value,
   input  wire logic [bcrm_pkg::CHAR_W-1:0]     req_seq_char,
   input  wire logic                            req_last_site,
   // job queue
   input  wire logic                            job_full,
   output      logic                            job_push,
   output      logic                            job_seq_enable,
   output      logic [bcrm_pkg::WIN_W-1:0]      job_window,
   output      logic [SUM_W-1:0]                job_sum,
   output      logic [CNT_W-1:0]                job_eligible,
   output      logic [CNT_W-1:0]                job_missing,
   output      logic [CNT_W-1:0]                job_snp
);

   localparam int CMP_W = (CNT_W > bcrm_pkg::BIN_W) ? CNT_W : bcrm_pkg::BIN_W;
   localparam logic [CMP_W-1:0] BIN_CAP = CMP_W'(1) << MAX_BIN_BITS;

   logic [bcrm_pkg::INTERVAL_W-1:0] low_ff, low_in;
   logic [bcrm_pkg::INTERVAL_W-1:0] high_ff, high_in;
   logic [bcrm_pkg::BIN_W-1:0]      bin_ff, bin_in;
   logic                            seq_en_ff, seq_en_in;

   logic [CNT_W-1:0]           site_ff, site_in;
   logic [bcrm_pkg::WIN_W-1:0] win_ff, win_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           elig_ff, elig_in;
   logic [CNT_W-1:0]           miss_ff, miss_in;
   logic [CNT_W-1:0]           snp_ff, snp_in;

   logic                   accept;
   logic                   eligible;
   logic [CMP_W-1:0]       bin_ext;
   logic [CMP_W-1:0]       eff_bin;
   logic                   close;
   logic [SUM_W-1:0]       sum_nx;
   logic [CNT_W-1:0]       elig_nx, miss_nx, snp_nx, site_nx;

   assign csr_ready = 1'b1;
   assign req_stall = job_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      bin_in    = bin_ff;
      seq_en_in = seq_en_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bcrm_pkg::CSR_INTERVAL_LOW:  low_in    = csr_data[bcrm_pkg::INTERVAL_W-1:0];
            bcrm_pkg::CSR_INTERVAL_HIGH: high_in   = csr_data[bcrm_pkg::INTERVAL_W-1:0];
            bcrm_pkg::CSR_BIN_SIZE:      bin_in    = csr_data;
            bcrm_pkg::CSR_SEQ_ENABLE:    seq_en_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // bin size of zero acts as one, oversize clamps to the cap
   always_comb begin
      bin_ext = CMP_W'(bin_ff);
      if (bin_ff == '0) begin
         eff_bin = CMP_W'(1);
      end else if (bin_ext > BIN_CAP) begin
         eff_bin = BIN_CAP;
      end else begin
         eff_bin = bin_ext;
      end
   end

   always_comb begin
      eligible = (req_interval_index >= low_ff) && (req_interval_index < high_ff);
      sum_nx   = eligible ? sum_ff + SUM_W'(req_rate_value) : sum_ff;
      elig_nx  = eligible ? elig_ff + CNT_W'(1) : elig_ff;
      miss_nx  = (req_seq_char == bcrm_pkg::CHAR_MISSING) ? miss_ff + CNT_W'(1) : miss_ff;
      snp_nx   = (req_seq_char == bcrm_pkg::CHAR_SNP) ? snp_ff + CNT_W'(1) : snp_ff;
      site_nx  = site_ff + CNT_W'(1);
      close    = req_last_site || (CMP_W'(site_nx) >= eff_bin);

      site_in = site_ff;
      win_in  = win_ff;
      sum_in  = sum_ff;
      elig_in = elig_ff;
      miss_in = miss_ff;
      snp_in  = snp_ff;
      if (accept) begin
         if (close) begin
            site_in = '0;
            sum_in  = '0;
            elig_in = '0;
            miss_in = '0;
            snp_in  = '0;
            win_in  = req_last_site ? '0 : win_ff + bcrm_pkg::WIN_W'(1);
         end else begin
            site_in = site_nx;
            sum_in  = sum_nx;
            elig_in = elig_nx;
            miss_in = miss_nx;
            snp_in  = snp_nx;
         end
      end
   end

   assign job_push       = accept && close;
   assign job_seq_enable = seq_en_ff;
   assign job_window     = win_ff;
   assign job_sum        = sum_nx;
   assign job_eligible   = elig_nx;
   assign job_missing    = miss_nx;
   assign job_snp        = snp_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= bcrm_pkg::DEF_LOW;
         high_ff   <= bcrm_pkg::DEF_HIGH;
         bin_ff    <= bcrm_pkg::DEF_BIN;
         seq_en_ff <= 1'b0;
         site_ff   <= '0;
         win_ff    <= '0;
         sum_ff    <= '0;
         elig_ff   <= '0;
         miss_ff   <= '0;
         snp_ff    <= '0;
      end else begin
         low_ff    <= low_in;
         high_ff   <= high_in;
         bin_ff    <= bin_in;
         seq_en_ff <= seq_en_in;
         site_ff   <= site_in;
         win_ff    <= win_in;
         sum_ff    <= sum_in;
         elig_ff   <= elig_in;
         miss_ff   <= miss_in;
         snp_ff    <= snp_in;
      end
   end

endmodule
`default_nettype wire

### rtl/bcrm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrm_fifo
// Small register queue holding closed windows until the shared divider takes them.
// ----------------------------------------------------------------------------
module bcrm_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = bcrm_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic [DATA_W-1:0] pop_data,
   output      logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### rtl/bcrm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrm_back
// Takes one closed window from the queue, runs its three divisions through a
// shared radix-2 restoring divider and registers the result word.
// ----------------------------------------------------------------------------
module bcrm_back #(
   parameter int MAX_BIN_BITS = bcrm_pkg::MAX_BIN_BITS_DEF,
   parameter int CNT_W        = MAX_BIN_BITS + 1,
   parameter int SUM_W        = bcrm_pkg::RATE_W + MAX_BIN_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // job queue
   input  wire logic                         job_empty,
   output      logic                         job_pop,
   input  wire logic                         job_seq_enable,
   input  wire logic [bcrm_pkg::WIN_W-1:0]   job_window,
   input  wire logic [SUM_W-1:0]             job_sum,
   input  wire logic [CNT_W-1:0]             job_eligible,
   input  wire logic [CNT_W-1:0]             job_missing,
   input  wire logic [CNT_W-1:0]             job_snp,
   // results
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [bcrm_pkg::WIN_W-1:0]   rsp_window_number,
   output      logic [bcrm_pkg::RATE_W-1:0]  rsp_mean_rate,
   output      logic                         rsp_mean_valid,
   output      logic [bcrm_pkg::BIN_W-1:0]   rsp_eligible_sites,
   output      logic [bcrm_pkg::RATIO_W-1:0] rsp_missing_fraction,
   output      logic [bcrm_pkg::RATIO_W-1:0] rsp_diversity,
   output      logic                         rsp_seq_valid
);

   localparam int DIV_W  = SUM_W;
   localparam int STEP_W = $clog2(DIV_W);

   function automatic logic [bcrm_pkg::RATIO_W-1:0] sat32(input logic [DIV_W-1:0] q);
      logic [bcrm_pkg::RATIO_W-1:0] r;
      if (|q[DIV_W-1:bcrm_pkg::RATIO_W]) begin
         r = '1;
      end else begin
         r = q[bcrm_pkg::RATIO_W-1:0];
      end
      return r;
   endfunction

   bcrm_pkg::back_state_type state_ff, state_in;

   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;

   logic                       seq_en_ff, seq_en_in;
   logic [bcrm_pkg::WIN_W-1:0] win_ff, win_in;
   logic [CNT_W-1:0]           elig_ff, elig_in;
   logic [CNT_W-1:0]           miss_ff, miss_in;
   logic [CNT_W-1:0]           snp_ff, snp_in;

   logic [bcrm_pkg::RATIO_W-1:0] mean_q_ff, mean_q_in;
   logic [bcrm_pkg::RATIO_W-1:0] miss_q_ff, miss_q_in;
   logic [bcrm_pkg::RATIO_W-1:0] div_q_ff, div_q_in;

   logic                         out_valid_ff, out_valid_in;
   logic [bcrm_pkg::WIN_W-1:0]   out_win_ff, out_win_in;
   logic [bcrm_pkg::RATE_W-1:0]  out_mean_ff, out_mean_in;
   logic                         out_mvalid_ff, out_mvalid_in;
   logic [bcrm_pkg::BIN_W-1:0]   out_elig_ff, out_elig_in;
   logic [bcrm_pkg::RATIO_W-1:0] out_miss_ff, out_miss_in;
   logic [bcrm_pkg::RATIO_W-1:0] out_div_ff, out_div_in;
   logic                         out_svalid_ff, out_svalid_in;

   // one quotient bit per cycle
   logic [CNT_W-1:0] den;
   logic [CNT_W:0]   shifted;
   logic [CNT_W:0]   diff;
   logic             ge;
   logic [CNT_W-1:0] step_rem;
   logic [DIV_W-1:0] step_quo;
   logic             last_step;
   logic             seq_ok;

   always_comb begin
      den      = (state_ff == bcrm_pkg::BK_DIV) ? elig_ff - miss_ff : elig_ff;
      shifted  = {rem_ff, quo_ff[DIV_W-1]};
      diff     = shifted - {1'b0, den};
      ge       = (shifted >= {1'b0, den});
      step_rem = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_quo = {quo_ff[DIV_W-2:0], ge};
      last_step = (cnt_ff == STEP_W'(DIV_W - 1));
      seq_ok   = seq_en_ff && (elig_ff != '0) && (elig_ff > miss_ff);
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      seq_en_in  = seq_en_ff;
      win_in     = win_ff;
      elig_in    = elig_ff;
      miss_in    = miss_ff;
      snp_in     = snp_ff;
      mean_q_in  = mean_q_ff;
      miss_q_in  = miss_q_ff;
      div_q_in   = div_q_ff;
      job_pop    = 1'b0;

      out_valid_in  = out_valid_ff && rsp_stall;
      out_win_in    = out_win_ff;
      out_mean_in   = out_mean_ff;
      out_mvalid_in = out_mvalid_ff;
      out_elig_in   = out_elig_ff;
      out_miss_in   = out_miss_ff;
      out_div_in    = out_div_ff;
      out_svalid_in = out_svalid_ff;

      case (state_ff)
         bcrm_pkg::BK_IDLE: begin
            if (!job_empty) begin
               job_pop   = 1'b1;
               seq_en_in = job_seq_enable;
               win_in    = job_window;
               elig_in   = job_eligible;
               miss_in   = job_missing;
               snp_in    = job_snp;
               rem_in    = '0;
               quo_in    = DIV_W'(job_sum);
               cnt_in    = '0;
               state_in  = bcrm_pkg::BK_MEAN;
            end
         end
         bcrm_pkg::BK_MEAN: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff + STEP_W'(1);
            if (last_step) begin
               mean_q_in = sat32(step_quo);
               rem_in    = '0;
               quo_in    = DIV_W'({miss_ff, bcrm_pkg::Q16_SHIFT'(0)});
               cnt_in    = '0;
               state_in  = bcrm_pkg::BK_MISS;
            end
         end
         bcrm_pkg::BK_MISS: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff + STEP_W'(1);
            if (last_step) begin
               miss_q_in = sat32(step_quo);
               rem_in    = '0;
               quo_in    = DIV_W'({snp_ff, bcrm_pkg::Q16_SHIFT'(0)});
               cnt_in    = '0;
               state_in  = bcrm_pkg::BK_DIV;
            end
         end
         bcrm_pkg::BK_DIV: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff + STEP_W'(1);
            if (last_step) begin
               div_q_in = sat32(step_quo);
               cnt_in   = '0;
               state_in = bcrm_pkg::BK_OUT;
            end
         end
         bcrm_pkg::BK_OUT: begin
            // zero divisors ran through the divider too; their quotients are masked here
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in  = 1'b1;
               out_win_in    = win_ff;
               out_mvalid_in = (elig_ff != '0);
               out_mean_in   = (elig_ff != '0) ? mean_q_ff : '0;
               out_elig_in   = bcrm_pkg::BIN_W'(elig_ff);
               out_miss_in   = seq_ok ? miss_q_ff : '0;
               out_div_in    = seq_ok ? div_q_ff : '0;
               out_svalid_in = seq_ok;
               state_in      = bcrm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = bcrm_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcrm_pkg::BK_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      seq_en_ff     <= seq_en_in;
      win_ff        <= win_in;
      elig_ff       <= elig_in;
      miss_ff       <= miss_in;
      snp_ff        <= snp_in;
      mean_q_ff     <= mean_q_in;
      miss_q_ff     <= miss_q_in;
      div_q_ff      <= div_q_in;
      out_win_ff    <= out_win_in;
      out_mean_ff   <= out_mean_in;
      out_mvalid_ff <= out_mvalid_in;
      out_elig_ff   <= out_elig_in;
      out_miss_ff   <= out_miss_in;
      out_div_ff    <= out_div_in;
      out_svalid_ff <= out_svalid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_window_number    = out_win_ff;
   assign rsp_mean_rate        = out_mean_ff;
   assign rsp_mean_valid       = out_mvalid_ff;
   assign rsp_eligible_sites   = out_elig_ff;
   assign rsp_missing_fraction = out_miss_ff;
   assign rsp_diversity        = out_div_ff;
   assign rsp_seq_valid        = out_svalid_ff;

endmodule
`default_nettype wire

### rtl/binned_conditional_rate_mean_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binned_conditional_rate_mean_unit
// Per-window mean rate, missing fraction and diversity over a stream of sites.
//
//  channel  dir  handshake              word
//  req_     in   req_valid/req_stall    one site
//  rsp_     out  rsp_valid/rsp_stall    one window result
//  csr_     in   csr_valid/csr_ready    register index + data
//
// The front takes one site per cycle; req_stall rises only while the window
// queue (QUEUE_DEPTH entries) is full. Each closed window goes through the back
// end one window at a time and runs its divisions on the shared divider
// that retires one quotient bit per cycle. Reset is synchronous and clears all
// counters at once; no clearing pass. rsp_stall holds the output register and,
// once the next window is finished, the back end too; the queue then fills.
// ----------------------------------------------------------------------------
module binned_conditional_rate_mean_unit #(
   parameter int MAX_BIN_BITS = bcrm_pkg::MAX_BIN_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [bcrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bcrm_pkg::BIN_W-1:0]      csr_data,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [bcrm_pkg::INTERVAL_W-1:0] req_interval_index,
   input  wire logic [bcrm_pkg::RATE_W-1:0]     req_rate_value,
   input  wire logic [bcrm_pkg::CHAR_W-1:0]     req_seq_char,
   input  wire logic                            req_last_site,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [bcrm_pkg::WIN_W-1:0]      rsp_window_number,
   output      logic [bcrm_pkg::RATE_W-1:0]     rsp_mean_rate,
   output      logic                            rsp_mean_valid,
   output      logic [bcrm_pkg::BIN_W-1:0]      rsp_eligible_sites,
   output      logic [bcrm_pkg::RATIO_W-1:0]    rsp_missing_fraction,
   output      logic [bcrm_pkg::RATIO_W-1:0]    rsp_diversity,
   output      logic                            rsp_seq_valid
);

   localparam int CNT_W = MAX_BIN_BITS + 1;
   localparam int SUM_W = bcrm_pkg::RATE_W + MAX_BIN_BITS;
   localparam int JOB_W = 1 + bcrm_pkg::WIN_W + SUM_W + 3 * CNT_W;

   logic                       push, full, pop, empty;
   logic [JOB_W-1:0]           push_word, pop_word;

   logic                       f_seq_en;
   logic [bcrm_pkg::WIN_W-1:0] f_win;
   logic [SUM_W-1:0]           f_sum;
   logic [CNT_W-1:0]           f_elig, f_miss, f_snp;

   logic                       b_seq_en;
   logic [bcrm_pkg::WIN_W-1:0] b_win;
   logic [SUM_W-1:0]           b_sum;
   logic [CNT_W-1:0]           b_elig, b_miss, b_snp;

   bcrm_front #(
      .MAX_BIN_BITS (MAX_BIN_BITS),
      .CNT_W        (CNT_W),
      .SUM_W        (SUM_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_interval_index (req_interval_index),
      .req_rate_value     (req_rate_value),
      .req_seq_char       (req_seq_char),
      .req_last_site      (req_last_site),
      .job_full           (full),
      .job_push           (push),
      .job_seq_enable     (f_seq_en),
      .job_window         (f_win),
      .job_sum            (f_sum),
      .job_eligible       (f_elig),
      .job_missing        (f_miss),
      .job_snp            (f_snp)
   );

   assign push_word = {f_seq_en, f_win, f_sum, f_elig, f_miss, f_snp};

   bcrm_fifo #(
      .DATA_W (JOB_W),
      .DEPTH  (bcrm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_word),
      .empty     (empty)
   );

   assign {b_seq_en, b_win, b_sum, b_elig, b_miss, b_snp} = pop_word;

   bcrm_back #(
      .MAX_BIN_BITS (MAX_BIN_BITS),
      .CNT_W        (CNT_W),
      .SUM_W        (SUM_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .job_empty            (empty),
      .job_pop              (pop),
      .job_seq_enable       (b_seq_en),
      .job_window           (b_win),
      .job_sum              (b_sum),
      .job_eligible         (b_elig),
      .job_missing          (b_miss),
      .job_snp              (b_snp),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_window_number    (rsp_window_number),
      .rsp_mean_rate        (rsp_mean_rate),
      .rsp_mean_valid       (rsp_mean_valid),
      .rsp_eligible_sites   (rsp_eligible_sites),
      .rsp_missing_fraction (rsp_missing_fraction),
      .rsp_diversity        (rsp_diversity),
      .rsp_seq_valid        (rsp_seq_valid)
   );

endmodule
`default_nettype wire
